// ===== sv/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_W     = $clog2(STACK_DEPTH);
  localparam int SP_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIVIDEND_W = 32 + FRAC_BITS;
  localparam int DCNT_W     = $clog2(DIVIDEND_W + 1);

  localparam logic [SP_W-1:0] DEPTH_SP = SP_W'(STACK_DEPTH);

  // token codes
  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_SUB   = 3'd2;
  localparam logic [2:0] MODE_MUL   = 3'd3;
  localparam logic [2:0] MODE_DIV   = 3'd4;
  localparam logic [2:0] MODE_REM   = 3'd5;
  localparam logic [2:0] MODE_PRINT = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_MODZERO = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_valid;
    logic [2:0]         status;
    logic [7:0]         stack_depth;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic        start;
    logic        is_rem;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } div_rsp_t;

endpackage

// ===== sv/rpn_stack_mem.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_mem
// Value stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpn_stack_mem (
  input  logic              clk_i,
  input  rpn_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [rpn_pkg::STACK_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rpn_divider.sv =====
// ----------------------------------------------------------------------------
// rpn_divider
// Restoring divider, one quotient bit per cycle. Fixed-point quotient with
// saturation, or remainder carrying the dividend's sign.
// ----------------------------------------------------------------------------
module rpn_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t rsp_o
);

  localparam int W = rpn_pkg::DIVIDEND_W;

  logic                         busy_q;
  logic                         done_q;
  logic [rpn_pkg::DCNT_W-1:0]   cnt_q;
  logic [W-1:0]                 num_q;
  logic [31:0]                  rem_q;
  logic [31:0]                  dvs_q;
  logic                         is_rem_q;
  logic                         neg_q;
  logic                         sign_a_q;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic        q_ovf;
  logic [31:0] quot;
  logic [31:0] remv;

  assign mag_a = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
  assign mag_b = req_i.divisor[31]  ? (32'd0 - req_i.divisor)  : req_i.divisor;

  assign shifted = {rem_q, num_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == rpn_pkg::DCNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= rpn_pkg::DCNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - rpn_pkg::DCNT_W'(1);
        if (cnt_q == rpn_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // remainder runs on the unscaled magnitude
      num_q    <= req_i.is_rem ? W'(mag_a) : (W'(mag_a) << rpn_pkg::FRAC_BITS);
      rem_q    <= '0;
      dvs_q    <= mag_b;
      is_rem_q <= req_i.is_rem;
      neg_q    <= req_i.dividend[31] ^ req_i.divisor[31];
      sign_a_q <= req_i.dividend[31];
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      num_q <= {num_q[W-2:0], ge};
    end
  end

  assign q_ovf = |num_q[W-1:31];

  always_comb begin
    if (q_ovf) begin
      quot = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      quot = neg_q ? (32'd0 - num_q[31:0]) : num_q[31:0];
    end
    remv = sign_a_q ? (32'd0 - rem_q) : rem_q;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = is_rem_q ? remv : quot;

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator over a signed Q16.16 value stack.
// ----------------------------------------------------------------------------
// One token per input transfer, one result per token. The block works on one
// token at a time; the stack pointer lives in a register and the values in a
// synchronous single-read-port memory, so each operand takes a read state
// (S_POP_B or S_POP_A) and then a capture state (S_GET_B or S_GET_A). Divide
// and remainder wait on the restoring divider (one quotient bit per cycle
// over 48 dividend bits). The next token is taken as soon as the result has
// moved into the output register, even while that result is still stalled.
// The stack memory has no reset; only entries below the stack pointer are
// ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpn_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpn_pkg::out_item_t out_item_o
);

  localparam int SP_W = rpn_pkg::SP_W;

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_POP_B    = 10'b00_0000_0010,
    S_GET_B    = 10'b00_0000_0100,
    S_POP_A    = 10'b00_0000_1000,
    S_GET_A    = 10'b00_0001_0000,
    S_OP       = 10'b00_0010_0000,
    S_MUL_SAT  = 10'b00_0100_0000,
    S_DIV_WAIT = 10'b00_1000_0000,
    S_PUSH     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [SP_W-1:0]  sp_q, sp_d;
  logic [SP_W-1:0]  sp_dec;
  logic [2:0]       status_q, status_d;
  logic             hit_q, hit_d;        // last pop found an entry
  logic             out_valid_q, out_valid_d;
  rpn_pkg::out_item_t out_q;

  // token payload and operands
  logic [2:0]         mode_q;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic [31:0]        res_q;
  logic signed [63:0] prod_q;

  logic               in_xfer;
  logic               out_free;
  logic [31:0]        mem_rdata;
  logic [31:0]        pop_val;
  logic signed [63:0] prod_sh;
  logic               prod_fits;
  logic [31:0]        mul_res;

  rpn_pkg::mem_req_t mem_req;
  rpn_pkg::div_req_t div_req;
  rpn_pkg::div_rsp_t div_rsp;

  rpn_stack_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rpn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sp_dec  = sp_q - SP_W'(1);
  // an empty pop reads as zero
  assign pop_val = hit_q ? mem_rdata : 32'd0;

  // floor(product / 2^F), saturated to 32 bits
  assign prod_sh   = prod_q >>> rpn_pkg::FRAC_BITS;
  assign prod_fits = (&prod_sh[63:31]) || !(|prod_sh[63:31]);
  assign mul_res   = prod_fits ? prod_sh[31:0]
                   : (prod_sh[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // sequencer: each state issues at most one stack access, so a read never
  // meets a write to the same entry in the same cycle
  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    status_d    = status_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    mem_req     = '0;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = rpn_pkg::ST_OK;
          case (in_item_i.mode)
            rpn_pkg::MODE_PUSH:  state_d = S_PUSH;
            rpn_pkg::MODE_ADD,
            rpn_pkg::MODE_SUB,
            rpn_pkg::MODE_MUL,
            rpn_pkg::MODE_DIV,
            rpn_pkg::MODE_REM,
            rpn_pkg::MODE_PRINT: state_d = S_POP_B;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_POP_B, S_POP_A: begin
        if (sp_q != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = sp_dec[rpn_pkg::ADDR_W-1:0];
          sp_d          = sp_dec;
          hit_d         = 1'b1;
        end else begin
          hit_d = 1'b0;
          if (status_q == rpn_pkg::ST_OK) begin
            status_d = rpn_pkg::ST_EMPTY;
          end
        end
        state_d = (state_q == S_POP_B) ? S_GET_B : S_GET_A;
      end
      S_GET_B: begin
        if (mode_q == rpn_pkg::MODE_PRINT) begin
          state_d = S_DONE;
        end else if ((mode_q == rpn_pkg::MODE_DIV || mode_q == rpn_pkg::MODE_REM)
                     && pop_val == 32'd0) begin
          // zero divisor: consumed, dividend left in place
          if (status_q == rpn_pkg::ST_OK) begin
            status_d = (mode_q == rpn_pkg::MODE_DIV) ? rpn_pkg::ST_DIVZERO
                                                     : rpn_pkg::ST_MODZERO;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_POP_A;
        end
      end
      S_GET_A: begin
        state_d = S_OP;
      end
      S_OP: begin
        case (mode_q)
          rpn_pkg::MODE_ADD,
          rpn_pkg::MODE_SUB: state_d = S_PUSH;
          rpn_pkg::MODE_MUL: state_d = S_MUL_SAT;
          rpn_pkg::MODE_DIV,
          rpn_pkg::MODE_REM: begin
            div_req.start    = 1'b1;
            div_req.is_rem   = (mode_q == rpn_pkg::MODE_REM);
            div_req.dividend = a_q;
            div_req.divisor  = b_q;
            state_d          = S_DIV_WAIT;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MUL_SAT: begin
        state_d = S_PUSH;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sp_q < rpn_pkg::DEPTH_SP) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = sp_q[rpn_pkg::ADDR_W-1:0];
          mem_req.wdata = res_q;
          sp_d          = sp_q + SP_W'(1);
        end else if (status_q == rpn_pkg::ST_OK) begin
          status_d = rpn_pkg::ST_FULL;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      status_q    <= rpn_pkg::ST_OK;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      status_q    <= status_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= in_item_i.mode;
    end
    if (state_q == S_IDLE) begin
      res_q <= in_item_i.operand_value;
    end
    if (state_q == S_GET_B) begin
      b_q <= pop_val;
    end
    if (state_q == S_GET_A) begin
      a_q <= pop_val;
    end
    if (state_q == S_OP) begin
      res_q  <= (mode_q == rpn_pkg::MODE_SUB) ? (a_q - b_q) : (a_q + b_q);
      prod_q <= 64'(a_q) * 64'(b_q);
    end
    if (state_q == S_MUL_SAT) begin
      res_q <= mul_res;
    end
    if (state_q == S_DIV_WAIT && div_rsp.done) begin
      res_q <= div_rsp.value;
    end
    if (state_q == S_DONE && out_free) begin
      out_q.result_valid <= (mode_q == rpn_pkg::MODE_PRINT);
      out_q.result_value <= (mode_q == rpn_pkg::MODE_PRINT) ? b_q : 32'sd0;
      out_q.status       <= status_q;
      out_q.stack_depth  <= 8'(sp_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= rpn_pkg::DEPTH_SP)
    else $error("stack pointer beyond depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (sp_q < rpn_pkg::DEPTH_SP) && (state_q == S_PUSH))
    else $error("stack write while full or outside push");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV_WAIT)
    else $error("divider finished with no operation waiting");

  a_push_moves_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |=> sp_q == $past(sp_q) + SP_W'(1))
    else $error("stack write without pointer advance");
`endif

endmodule
